// ----- design/tadc_pkg.sv -----
// Shared types, constants and calibration table for the thermistor converter.
// Used by tadc_seq, tadc_datapath and thermistor_adc_to_temperature_core.
`timescale 1ns / 1ps
`default_nettype none

package tadc_pkg;

   localparam int TABLE_POINTS = 18;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int CODE_W       = 10;
   localparam int SERIES_W     = 17;
   localparam int OHMS_W       = 15;
   localparam int TEMP_W       = 14;
   localparam int STATUS_W     = 2;
   localparam int C16_W        = 13;
   localparam int NUM_W        = SERIES_W + CODE_W;
   localparam int PROD_W       = 25;
   localparam int QUO_W        = 8;
   localparam int CNT_W        = $clog2(QUO_W);
   localparam int REM_W        = 35;
   localparam int PC_W         = 5;
   localparam int FY_W         = 15;
   localparam int RECIP_W      = 16;
   localparam int FP_W         = FY_W + RECIP_W;
   localparam int RECIP_SHIFT  = 18;

   localparam logic [CODE_W-1:0]   ADC_FULL_SCALE   = 10'd1023;
   localparam logic [SERIES_W-1:0] SERIES_RESET     = 17'd2200;
   localparam logic [RECIP_W-1:0]  RECIP_FIVE       = 16'd52429;
   localparam logic signed [16:0]  F_SCALE_MUL      = 17'sd9;
   localparam logic signed [16:0]  F_SCALE_BIAS     = 17'sd3202;
   localparam logic signed [TEMP_W-1:0] F_OUT_BIAS  = 14'sd128;
   localparam logic signed [C16_W-1:0]  C16_COLD    = -13'sd320;
   localparam logic signed [C16_W-1:0]  C16_HOT     = 13'sd2400;

   localparam logic CSR_SERIES_RES = 1'b0;
   localparam logic CSR_FAHRENHEIT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_IN_TABLE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_COLD     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HOT      = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_NUM,
      OP_MUL_HI,
      OP_MUL_LO,
      OP_NEXT,
      OP_DIFF,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_INTERP,
      OP_HOT_END,
      OP_COLD_END,
      OP_F_SCALE,
      OP_F_MUL,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_COLD,
      COND_GT,
      COND_LAST,
      COND_CNT_NZ,
      COND_BUSY
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic cold;
      logic gt;
      logic last;
      logic cnt_nz;
      logic busy;
   } flags_type;

   function automatic logic [OHMS_W-1:0] tbl_ohms(input logic [IDX_W-1:0] idx);
      logic [OHMS_W-1:0] r;
      case (idx)
         5'd0:    r = 15'd28136;
         5'd1:    r = 15'd15813;
         5'd2:    r = 15'd9319;
         5'd3:    r = 15'd5589;
         5'd4:    r = 15'd3476;
         5'd5:    r = 15'd2230;
         5'd6:    r = 15'd1466;
         5'd7:    r = 15'd984;
         5'd8:    r = 15'd671;
         5'd9:    r = 15'd468;
         5'd10:   r = 15'd332;
         5'd11:   r = 15'd239;
         5'd12:   r = 15'd175;
         5'd13:   r = 15'd129;
         5'd14:   r = 15'd97;
         5'd15:   r = 15'd73;
         5'd16:   r = 15'd57;
         5'd17:   r = 15'd43;
         default: r = 15'd43;
      endcase
      return r;
   endfunction

   // temperature of each point in 1/16 degree C
   function automatic logic signed [C16_W-1:0] tbl_c16(input logic [IDX_W-1:0] idx);
      logic signed [C16_W-1:0] t;
      case (idx)
         5'd0:    t = -13'sd320;
         5'd1:    t = -13'sd160;
         5'd2:    t = 13'sd0;
         5'd3:    t = 13'sd160;
         5'd4:    t = 13'sd320;
         5'd5:    t = 13'sd480;
         5'd6:    t = 13'sd640;
         5'd7:    t = 13'sd800;
         5'd8:    t = 13'sd960;
         5'd9:    t = 13'sd1120;
         5'd10:   t = 13'sd1280;
         5'd11:   t = 13'sd1440;
         5'd12:   t = 13'sd1600;
         5'd13:   t = 13'sd1760;
         5'd14:   t = 13'sd1920;
         5'd15:   t = 13'sd2080;
         5'd16:   t = 13'sd2240;
         5'd17:   t = 13'sd2400;
         default: t = 13'sd2400;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- design/tadc_seq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
// Depends on tadc_pkg for the control word and flag types.
`timescale 1ns / 1ps
`default_nettype none

module tadc_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tadc_pkg::flags_type flags,
   output tadc_pkg::ctrl_type      ctrl
);

   localparam logic [tadc_pkg::PC_W-1:0] S_IDLE   = 5'd0;
   localparam logic [tadc_pkg::PC_W-1:0] S_MUL_LO = 5'd4;
   localparam logic [tadc_pkg::PC_W-1:0] S_DIFF   = 5'd8;
   localparam logic [tadc_pkg::PC_W-1:0] S_DIV    = 5'd10;
   localparam logic [tadc_pkg::PC_W-1:0] S_HOT    = 5'd12;
   localparam logic [tadc_pkg::PC_W-1:0] S_COLD   = 5'd13;
   localparam logic [tadc_pkg::PC_W-1:0] S_FAHR   = 5'd14;
   localparam logic [tadc_pkg::PC_W-1:0] S_EMIT   = 5'd16;

   function automatic tadc_pkg::ctrl_type rom(input logic [tadc_pkg::PC_W-1:0] pc);
      tadc_pkg::ctrl_type w;
      case (pc)
         5'd0:    w = '{tadc_pkg::OP_LOAD,     tadc_pkg::COND_NO_REQ, S_IDLE};
         5'd1:    w = '{tadc_pkg::OP_MUL_NUM,  tadc_pkg::COND_NEVER,  S_IDLE};
         5'd2:    w = '{tadc_pkg::OP_MUL_HI,   tadc_pkg::COND_NEVER,  S_IDLE};
         5'd3:    w = '{tadc_pkg::OP_NOP,      tadc_pkg::COND_COLD,   S_COLD};
         5'd4:    w = '{tadc_pkg::OP_MUL_LO,   tadc_pkg::COND_NEVER,  S_IDLE};
         5'd5:    w = '{tadc_pkg::OP_NOP,      tadc_pkg::COND_GT,     S_DIFF};
         5'd6:    w = '{tadc_pkg::OP_NOP,      tadc_pkg::COND_LAST,   S_HOT};
         5'd7:    w = '{tadc_pkg::OP_NEXT,     tadc_pkg::COND_ALWAYS, S_MUL_LO};
         5'd8:    w = '{tadc_pkg::OP_DIFF,     tadc_pkg::COND_NEVER,  S_IDLE};
         5'd9:    w = '{tadc_pkg::OP_DIV_INIT, tadc_pkg::COND_NEVER,  S_IDLE};
         5'd10:   w = '{tadc_pkg::OP_DIV_STEP, tadc_pkg::COND_CNT_NZ, S_DIV};
         5'd11:   w = '{tadc_pkg::OP_INTERP,   tadc_pkg::COND_ALWAYS, S_FAHR};
         5'd12:   w = '{tadc_pkg::OP_HOT_END,  tadc_pkg::COND_ALWAYS, S_FAHR};
         5'd13:   w = '{tadc_pkg::OP_COLD_END, tadc_pkg::COND_NEVER,  S_IDLE};
         5'd14:   w = '{tadc_pkg::OP_F_SCALE,  tadc_pkg::COND_NEVER,  S_IDLE};
         5'd15:   w = '{tadc_pkg::OP_F_MUL,    tadc_pkg::COND_NEVER,  S_IDLE};
         5'd16:   w = '{tadc_pkg::OP_EMIT,     tadc_pkg::COND_BUSY,   S_EMIT};
         default: w = '{tadc_pkg::OP_NOP,      tadc_pkg::COND_ALWAYS, S_IDLE};
      endcase
      return w;
   endfunction

   logic [tadc_pkg::PC_W-1:0] pc_ff;
   logic [tadc_pkg::PC_W-1:0] pc_in;
   logic                      take;

   assign ctrl = rom(pc_ff);

   always_comb begin
      case (ctrl.cond)
         tadc_pkg::COND_NEVER:  take = 1'b0;
         tadc_pkg::COND_ALWAYS: take = 1'b1;
         tadc_pkg::COND_NO_REQ: take = !flags.req_valid;
         tadc_pkg::COND_COLD:   take = flags.cold;
         tadc_pkg::COND_GT:     take = flags.gt;
         tadc_pkg::COND_LAST:   take = flags.last;
         tadc_pkg::COND_CNT_NZ: take = flags.cnt_nz;
         tadc_pkg::COND_BUSY:   take = flags.busy;
         default:               take = 1'b0;
      endcase
      pc_in = take ? ctrl.target : tadc_pkg::PC_W'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/tadc_datapath.sv -----
// Datapath: config registers, shared multiplier, search registers, divider,
// Fahrenheit scaling and the result register. Depends on tadc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tadc_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tadc_pkg::ctrl_type                    ctrl,
   output tadc_pkg::flags_type                        flags,
   input  wire logic                                  csr_write,
   input  wire logic                                  csr_index,
   input  wire logic [tadc_pkg::SERIES_W-1:0]         csr_wdata,
   input  wire logic                                  req_valid,
   input  wire logic [tadc_pkg::CODE_W-1:0]           req_adc_code,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [tadc_pkg::TEMP_W-1:0]         rsp_temperature,
   output logic [tadc_pkg::STATUS_W-1:0]              rsp_clamp_status
);

   logic [tadc_pkg::SERIES_W-1:0]     series_ff;
   logic                              fahr_ff;
   logic [tadc_pkg::CODE_W-1:0]       den_ff;
   logic [tadc_pkg::CODE_W-1:0]       span_ff;
   logic [tadc_pkg::NUM_W-1:0]        num_ff;
   logic [tadc_pkg::PROD_W-1:0]       hi_ff;
   logic [tadc_pkg::PROD_W-1:0]       lo_ff;
   logic [tadc_pkg::IDX_W-1:0]        idx_ff;
   logic [tadc_pkg::PROD_W-1:0]       a_ff;
   logic [tadc_pkg::PROD_W-1:0]       d_ff;
   logic [tadc_pkg::REM_W-1:0]        rem_ff;
   logic [tadc_pkg::PROD_W:0]         dvs_ff;
   logic [tadc_pkg::QUO_W-1:0]        quo_ff;
   logic [tadc_pkg::CNT_W-1:0]        cnt_ff;
   logic signed [tadc_pkg::C16_W-1:0] c16_ff;
   logic [tadc_pkg::STATUS_W-1:0]     status_ff;
   logic [tadc_pkg::FY_W-1:0]         fy_ff;
   logic [tadc_pkg::FP_W-1:0]         fp_ff;
   logic                              rsp_valid_ff;
   logic signed [tadc_pkg::TEMP_W-1:0] rsp_temp_ff;
   logic [tadc_pkg::STATUS_W-1:0]     rsp_status_ff;

   logic [tadc_pkg::SERIES_W-1:0]     mul_a;
   logic [tadc_pkg::CODE_W-1:0]       mul_b;
   logic [tadc_pkg::NUM_W-1:0]        mul_p;
   logic [tadc_pkg::IDX_W-1:0]        idx_next;
   logic [tadc_pkg::REM_W-1:0]        div_trial;
   logic [tadc_pkg::REM_W-1:0]        div_init;
   logic signed [16:0]                f_scaled;
   logic signed [tadc_pkg::TEMP_W-1:0] temp_f;
   logic signed [tadc_pkg::TEMP_W-1:0] temp_out;
   logic                              busy;
   logic                              load;

   assign busy     = rsp_valid_ff && rsp_stall;
   assign load     = (ctrl.op == tadc_pkg::OP_LOAD) && req_valid;
   assign idx_next = tadc_pkg::IDX_W'(idx_ff + 1'b1);

   // shared multiplier: series*span or table resistance*code
   always_comb begin
      case (ctrl.op)
         tadc_pkg::OP_MUL_NUM: begin
            mul_a = series_ff;
            mul_b = span_ff;
         end
         tadc_pkg::OP_MUL_LO: begin
            mul_a = {2'b00, tadc_pkg::tbl_ohms(idx_next)};
            mul_b = den_ff;
         end
         default: begin
            mul_a = {2'b00, tadc_pkg::tbl_ohms(idx_ff)};
            mul_b = den_ff;
         end
      endcase
      mul_p = {{tadc_pkg::CODE_W{1'b0}}, mul_a} * {{tadc_pkg::SERIES_W{1'b0}}, mul_b};
   end

   assign div_trial = tadc_pkg::REM_W'(dvs_ff) << cnt_ff;
   assign div_init  = (tadc_pkg::REM_W'(a_ff) << 8) + (tadc_pkg::REM_W'(a_ff) << 6)
                      + tadc_pkg::REM_W'(d_ff);
   assign f_scaled  = 17'(c16_ff) * tadc_pkg::F_SCALE_MUL + tadc_pkg::F_SCALE_BIAS;
   assign temp_f    = $signed({1'b0, fp_ff[tadc_pkg::FP_W-1:tadc_pkg::RECIP_SHIFT]})
                      - tadc_pkg::F_OUT_BIAS;
   assign temp_out  = fahr_ff ? temp_f : tadc_pkg::TEMP_W'(c16_ff);

   always_comb begin
      flags.req_valid = req_valid;
      flags.cold      = (den_ff == '0) || (num_ff > tadc_pkg::NUM_W'(hi_ff));
      flags.gt        = num_ff > tadc_pkg::NUM_W'(lo_ff);
      flags.last      = idx_ff == tadc_pkg::IDX_W'(tadc_pkg::TABLE_POINTS - 2);
      flags.cnt_nz    = cnt_ff != '0;
      flags.busy      = busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff <= tadc_pkg::SERIES_RESET;
         fahr_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            tadc_pkg::CSR_SERIES_RES: series_ff <= csr_wdata;
            tadc_pkg::CSR_FAHRENHEIT: fahr_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.op == tadc_pkg::OP_EMIT && !busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         tadc_pkg::OP_LOAD: begin
            if (load) begin
               den_ff  <= req_adc_code;
               span_ff <= (req_adc_code >= tadc_pkg::ADC_FULL_SCALE) ? '0
                          : tadc_pkg::ADC_FULL_SCALE - req_adc_code;
               idx_ff  <= '0;
            end
         end
         tadc_pkg::OP_MUL_NUM: num_ff <= mul_p;
         tadc_pkg::OP_MUL_HI:  hi_ff  <= mul_p[tadc_pkg::PROD_W-1:0];
         tadc_pkg::OP_MUL_LO:  lo_ff  <= mul_p[tadc_pkg::PROD_W-1:0];
         tadc_pkg::OP_NEXT: begin
            idx_ff <= idx_next;
            hi_ff  <= lo_ff;
         end
         tadc_pkg::OP_DIFF: begin
            a_ff <= hi_ff - num_ff[tadc_pkg::PROD_W-1:0];
            d_ff <= hi_ff - lo_ff;
         end
         tadc_pkg::OP_DIV_INIT: begin
            rem_ff <= div_init;
            dvs_ff <= {d_ff, 1'b0};
            quo_ff <= '0;
            cnt_ff <= '1;
         end
         tadc_pkg::OP_DIV_STEP: begin
            if (rem_ff >= div_trial) begin
               rem_ff         <= rem_ff - div_trial;
               quo_ff[cnt_ff] <= 1'b1;
            end
            cnt_ff <= tadc_pkg::CNT_W'(cnt_ff - 1'b1);
         end
         tadc_pkg::OP_INTERP: begin
            c16_ff    <= tadc_pkg::tbl_c16(idx_ff)
                         + $signed({{(tadc_pkg::C16_W - tadc_pkg::QUO_W){1'b0}}, quo_ff});
            status_ff <= tadc_pkg::STATUS_IN_TABLE;
         end
         tadc_pkg::OP_HOT_END: begin
            c16_ff    <= tadc_pkg::C16_HOT;
            status_ff <= (num_ff < tadc_pkg::NUM_W'(lo_ff)) ? tadc_pkg::STATUS_HOT
                         : tadc_pkg::STATUS_IN_TABLE;
         end
         tadc_pkg::OP_COLD_END: begin
            c16_ff    <= tadc_pkg::C16_COLD;
            status_ff <= tadc_pkg::STATUS_COLD;
         end
         tadc_pkg::OP_F_SCALE: fy_ff <= f_scaled[tadc_pkg::FY_W-1:0];
         tadc_pkg::OP_F_MUL:
            fp_ff <= {{tadc_pkg::RECIP_W{1'b0}}, fy_ff} * {{tadc_pkg::FY_W{1'b0}}, tadc_pkg::RECIP_FIVE};
         tadc_pkg::OP_EMIT: begin
            if (!busy) begin
               rsp_temp_ff   <= temp_out;
               rsp_status_ff <= status_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temperature  = rsp_temp_ff;
   assign rsp_clamp_status = rsp_status_ff;

endmodule

`default_nettype wire

// ----- design/thermistor_adc_to_temperature_core.sv -----
// Time from accept to rsp_valid depends on the path (cold clamp, hot end or segment i),
// set by the segment search loop and the 8-step divider; rsp_stall can hold the result.
// One item at a time: a new request is accepted only once the previous result is emitted.
// Reset: synchronous, active high; clears the step counter and result valid,
// loads series_resistance = 2200 and Celsius mode. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module thermistor_adc_to_temperature_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic                                  csr_index,
   input  wire logic [tadc_pkg::SERIES_W-1:0]         csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [tadc_pkg::CODE_W-1:0]           req_adc_code,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [tadc_pkg::TEMP_W-1:0]         rsp_temperature,
   output logic [tadc_pkg::STATUS_W-1:0]              rsp_clamp_status
);

   tadc_pkg::ctrl_type  ctrl;
   tadc_pkg::flags_type flags;

   assign req_stall = ctrl.op != tadc_pkg::OP_LOAD;

   tadc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   tadc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .flags            (flags),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_adc_code     (req_adc_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_temperature  (rsp_temperature),
      .rsp_clamp_status (rsp_clamp_status)
   );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for thermistor_adc_to_temperature_core.
// Predicts each temperature reading from the ADC code and the register settings;
// depends on tadc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS  = 190;
   localparam int PHASES       = 8;
   localparam int LAST_POINT   = tadc_pkg::TABLE_POINTS - 1;

   localparam int unsigned CAL_OHMS [tadc_pkg::TABLE_POINTS] = '{
      28136, 15813, 9319, 5589, 3476, 2230, 1466, 984, 671,
      468, 332, 239, 175, 129, 97, 73, 57, 43
   };
   localparam int CAL_DEG [tadc_pkg::TABLE_POINTS] = '{
      -20, -10, 0, 10, 20, 30, 40, 50, 60,
      70, 80, 90, 100, 110, 120, 130, 140, 150
   };

   typedef struct packed {
      logic [tadc_pkg::CODE_W-1:0]          code;
      logic signed [tadc_pkg::TEMP_W-1:0]   temperature;
      logic [tadc_pkg::STATUS_W-1:0]        clamp_status;
   } reading_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  csr_write;
   logic                                  csr_index;
   logic [tadc_pkg::SERIES_W-1:0]         csr_wdata;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [tadc_pkg::CODE_W-1:0]           req_adc_code;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic signed [tadc_pkg::TEMP_W-1:0]    rsp_temperature;
   logic [tadc_pkg::STATUS_W-1:0]         rsp_clamp_status;

   logic [tadc_pkg::SERIES_W-1:0]         cfg_series;
   logic                                  cfg_fahrenheit;
   reading_type                           pending_readings [$];
   reading_type                           due;
   int unsigned                           gap_pct = 0;
   int unsigned                           stall_pct = 0;
   int                                    items_sent = 0;
   int                                    readings_checked = 0;
   int                                    settings_used = 0;
   int                                    mismatches = 0;
   int                                    cycle_count = 0;

   thermistor_adc_to_temperature_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_code     (req_adc_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_temperature  (rsp_temperature),
      .rsp_clamp_status (rsp_clamp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic reading_type predict_reading(input logic [tadc_pkg::CODE_W-1:0] code);
      longint      num;
      longint      den;
      longint      hi;
      longint      lo;
      longint      c16;
      longint      frac;
      logic        found;
      reading_type r;
      den = longint'(code);
      num = (code >= tadc_pkg::ADC_FULL_SCALE) ? 0
            : longint'(cfg_series) * (longint'(tadc_pkg::ADC_FULL_SCALE) - longint'(code));
      r.code = code;
      r.clamp_status = tadc_pkg::STATUS_IN_TABLE;
      found = 1'b0;
      if (den == 0 || num > longint'(CAL_OHMS[0]) * den) begin
         c16 = CAL_DEG[0] * 16;
         r.clamp_status = tadc_pkg::STATUS_COLD;
      end else if (num < longint'(CAL_OHMS[LAST_POINT]) * den) begin
         c16 = CAL_DEG[LAST_POINT] * 16;
         r.clamp_status = tadc_pkg::STATUS_HOT;
      end else begin
         c16 = CAL_DEG[LAST_POINT] * 16;
         for (int seg = 0; seg < LAST_POINT; seg++) begin
            hi = longint'(CAL_OHMS[seg]) * den;
            lo = longint'(CAL_OHMS[seg + 1]) * den;
            if (!found && num > lo) begin
               frac = (longint'(2 * 16 * (CAL_DEG[seg + 1] - CAL_DEG[seg])) * (hi - num)
                       + (hi - lo)) / (2 * (hi - lo));
               c16 = longint'(CAL_DEG[seg] * 16) + frac;
               found = 1'b1;
            end
         end
      end
      // bias keeps the dividend positive so the division floors
      if (cfg_fahrenheit)
         c16 = (c16 * 9 + 500002) / 5 - 100000 + 512;
      r.temperature = c16[tadc_pkg::TEMP_W-1:0];
      return r;
   endfunction

   function automatic logic [tadc_pkg::CODE_W-1:0] pick_code();
      int unsigned sel;
      int          k;
      longint      aim;
      sel = $urandom_range(99);
      if (sel < 70)
         return tadc_pkg::CODE_W'($urandom_range(1023));
      if (sel < 85)
         return tadc_pkg::CODE_W'($urandom_range(1) ? $urandom_range(31)
                                                     : $urandom_range(1023, 992));
      // aim near a calibration point for the current divider resistor
      k = $urandom_range(LAST_POINT);
      aim = (longint'(tadc_pkg::ADC_FULL_SCALE) * longint'(cfg_series))
            / (longint'(cfg_series) + longint'(CAL_OHMS[k]));
      aim = aim + longint'(int'($urandom_range(4))) - 2;
      if (aim < 0)
         aim = 0;
      if (aim > 1023)
         aim = 1023;
      return aim[tadc_pkg::CODE_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic send_code(input logic [tadc_pkg::CODE_W-1:0] code);
      @(negedge clock);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_adc_code <= code;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(predict_reading(code));
      items_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_readings.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [tadc_pkg::SERIES_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_config(input logic [tadc_pkg::SERIES_W-1:0] series,
                               input logic [tadc_pkg::SERIES_W-1:0] fahr_word);
      release_req();
      wait_idle();
      write_csr(tadc_pkg::CSR_SERIES_RES, series);
      write_csr(tadc_pkg::CSR_FAHRENHEIT, fahr_word);
      cfg_series = series;
      cfg_fahrenheit = fahr_word[0];
      settings_used++;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            gap_pct = 0;
            stall_pct = 0;
         end
         1: begin
            gap_pct = 78;
            stall_pct = 0;
         end
         2: begin
            gap_pct = 0;
            stall_pct = 78;
         end
         default: begin
            gap_pct = 20;
            stall_pct = 20;
         end
      endcase
   endtask

   task automatic test_clamp_ends();
      set_idling(0);
      send_code(10'd0);
      send_code(10'd1);
      send_code(10'd2);
      send_code(10'd341);
      send_code(10'd512);
      send_code(10'd1021);
      send_code(10'd1022);
      send_code(10'd1023);
   endtask

   task automatic test_exact_points();
      // divider ratio 2:1 at code 341, 1:2 at code 682
      apply_config(17'd14068, 17'd0);
      send_code(10'd341);
      send_code(10'd340);
      send_code(10'd342);
      apply_config(17'd86, 17'd0);
      send_code(10'd682);
      apply_config(17'd1115, 17'd0);
      send_code(10'd341);
   endtask

   task automatic test_fahrenheit_scale();
      apply_config(17'd2200, 17'd1);
      send_code(10'd0);
      send_code(10'd1023);
      send_code(10'd512);
      send_code(10'd100);
      send_code(10'd900);
   endtask

   task automatic test_series_extremes();
      apply_config(17'd0, 17'h1FFFE);
      send_code(10'd512);
      apply_config(17'h1FFFF, 17'd1);
      send_code(10'd1);
      send_code(10'd1000);
      apply_config(17'd100, 17'd0);
      send_code(10'd10);
      send_code(10'd1000);
   endtask

   task automatic test_random_phases();
      logic [tadc_pkg::SERIES_W-1:0] series;
      for (int phase = 0; phase < PHASES; phase++) begin
         set_idling(phase % 4);
         case (phase)
            0:       series = 17'd2200;
            1:       series = 17'd100;
            2:       series = 17'd100000;
            3:       series = tadc_pkg::SERIES_W'($urandom_range(100000, 100));
            4:       series = 17'h1FFFF;
            5:       series = tadc_pkg::SERIES_W'($urandom_range(17'h1FFFF));
            6:       series = 17'd1000;
            default: series = 17'd10000;
         endcase
         apply_config(series, {16'($urandom_range(16'hFFFF)), 1'(phase / 4)});
         repeat (PHASE_ITEMS)
            send_code(pick_code());
      end
      release_req();
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("unrequested reading %0d status %0d",
                                      rsp_temperature, rsp_clamp_status));
         end else begin
            due = pending_readings.pop_front();
            readings_checked++;
            if (rsp_temperature !== due.temperature)
               report_mismatch($sformatf("code %0d: temperature %0d, predicted %0d",
                                         due.code, rsp_temperature, due.temperature));
            if (rsp_clamp_status !== due.clamp_status)
               report_mismatch($sformatf("code %0d: clamp status %0d, predicted %0d",
                                         due.code, rsp_clamp_status, due.clamp_status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d readings outstanding",
                  cycle_count, pending_readings.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_adc_code = '0;
      cfg_series = 17'd2200;
      cfg_fahrenheit = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_clamp_ends();
      test_exact_points();
      test_fahrenheit_scale();
      test_series_extremes();
      test_random_phases();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d ADC codes, checked %0d readings over %0d register settings.",
               items_sent, readings_checked, settings_used);
      $display("Covered both clamp ends, exact table points, Celsius and Fahrenheit, %s",
               "and four source/sink idle mixes.");
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
